// ===== hdl/crcfr_pkg.sv =====
// ----------------------------------------------------------------------------
// crcfr_pkg
// shared types, register indexes and the crc-16 byte update for the framer
// ----------------------------------------------------------------------------
package crcfr_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam int CSR_INDEX_WIDTH = 8;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_CODE = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_END_CODE   = 8'd1;

   localparam logic [7:0]  START_CODE_RESET = 8'h02;
   localparam logic [7:0]  END_CODE_RESET   = 8'h03;
   localparam logic [15:0] CRC_POLY         = 16'h1021;
   localparam logic [15:0] CRC_INIT         = 16'hFFFF;

   // one classified payload byte, handed from the front to the back
   typedef struct packed {
      logic [7:0]  data_byte;
      logic [15:0] payload_length;
      logic        first;
      logic        last;
      logic [15:0] crc;
      logic [7:0]  start_code;
      logic [7:0]  end_code;
   } entry_type;

   // crc-16/ccitt-false, one byte, msb first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_i,
                                            input logic [7:0]  data_i);
      logic [15:0] c;
      logic        fb;
      c = crc_i;
      for (int k = 7; k >= 0; k--) begin
         fb = c[15] ^ data_i[k];
         c  = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

endpackage

// ===== hdl/crc16_packet_framer.sv =====
// ----------------------------------------------------------------------------
// crc16_packet_framer
// wraps payload bytes into start/length/payload/crc16/end frames
// ----------------------------------------------------------------------------
// Each payload byte on the req_ stream yields framed bytes on the rsp_ stream:
// the first byte of a frame yields start code, length low, length high and the
// byte; a middle byte yields itself; a byte with req_tlast set yields itself,
// crc high, crc low and end code (a one-byte frame yields all seven). The crc
// is crc-16/ccitt-false over the payload only, and the length is copied as
// given. rsp_tlast marks the last transfer caused by one input item and
// rsp_tuser marks the end code. The front takes one byte per cycle into a
// QUEUE_DEPTH entry queue; the back emits one framed byte per cycle unless
// it runs dry or rsp_tready stalls it. A frame of n payload bytes gives
// n+6 framed bytes, and the input runs at one byte per cycle until the
// queue fills. With the back idle, an accepted byte goes from a queue slot
// through cur_ff to the output register. Code registers are written over the
// csr_ port at index 0 (start code) and 1 (end code), other indexes ignored.
// ----------------------------------------------------------------------------
module crc16_packet_framer #(
   parameter int QUEUE_DEPTH = crcfr_pkg::QUEUE_DEPTH  // 2 or more
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // payload byte stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [23:0]                           req_tdata,  // data_byte, payload_length
   input  logic                                  req_tlast,  // last_byte
   // framed byte stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [7:0]                            rsp_tdata,  // out_byte
   output logic                                  rsp_tuser,  // end_of_frame
   output logic                                  rsp_tlast,  // run_last
   // register writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [crcfr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [7:0]                            csr_wdata
);

   // queue push and pop sides
   crcfr_pkg::entry_type push_entry;
   crcfr_pkg::entry_type head_entry;
   logic                 q_push, q_full;
   logic                 q_pop, q_empty;

   // front: classify byte, update crc, hold code registers
   crcfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   // decoupling queue
   crcfr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_entry (head_entry),
      .empty      (q_empty)
   );

   // back: header/payload/trailer sequencer and output register
   crcfr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (head_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== hdl/crcfr_front.sv =====
// ----------------------------------------------------------------------------
// crcfr_front
// accepts payload bytes, tracks frame position and crc, holds the code registers
// ----------------------------------------------------------------------------
module crcfr_front (
   input  logic                                  clock,
   input  logic                                  reset,
   // input stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [23:0]                           req_tdata,  // data_byte, payload_length
   input  logic                                  req_tlast,
   // configuration writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [crcfr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [7:0]                            csr_wdata,
   // queue push side
   input  logic                                  q_full,
   output logic                                  q_push,
   output crcfr_pkg::entry_type                  q_entry
);

   logic [7:0]  start_code_ff, start_code_in;
   logic [7:0]  end_code_ff, end_code_in;
   logic [15:0] crc_ff, crc_in;
   logic        inside_ff, inside_in;
   logic [15:0] crc_base;
   logic [15:0] crc_next;
   logic        accept;

   assign csr_ready  = 1'b1;
   assign req_tready = ~q_full;
   assign accept     = req_tvalid & req_tready;

   assign crc_base = inside_ff ? crc_ff : crcfr_pkg::CRC_INIT;
   assign crc_next = crcfr_pkg::crc_byte(crc_base, req_tdata[7:0]);

   always_comb begin
      start_code_in = start_code_ff;
      end_code_in   = end_code_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == crcfr_pkg::CSR_START_CODE) begin
            start_code_in = csr_wdata;
         end else if (csr_index == crcfr_pkg::CSR_END_CODE) begin
            end_code_in = csr_wdata;
         end
      end
   end

   always_comb begin
      crc_in    = crc_ff;
      inside_in = inside_ff;
      if (accept) begin
         crc_in    = req_tlast ? crcfr_pkg::CRC_INIT : crc_next;
         inside_in = ~req_tlast;
      end
   end

   always_comb begin
      q_push                 = accept;
      q_entry.data_byte      = req_tdata[7:0];
      q_entry.payload_length = req_tdata[23:8];
      q_entry.first          = ~inside_ff;
      q_entry.last           = req_tlast;
      q_entry.crc            = crc_next;
      q_entry.start_code     = start_code_ff;
      q_entry.end_code       = end_code_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_code_ff <= crcfr_pkg::START_CODE_RESET;
         end_code_ff   <= crcfr_pkg::END_CODE_RESET;
         crc_ff        <= crcfr_pkg::CRC_INIT;
         inside_ff     <= 1'b0;
      end else begin
         start_code_ff <= start_code_in;
         end_code_ff   <= end_code_in;
         crc_ff        <= crc_in;
         inside_ff     <= inside_in;
      end
   end

`ifndef NO_ASSERTIONS
   // between frames the running crc is parked at its initial value
   a_crc_parked: assert property (@(posedge clock) disable iff (reset)
      !inside_ff |-> crc_ff == crcfr_pkg::CRC_INIT)
      else $error("crc not at initial value outside a frame");
`endif

endmodule

// ===== hdl/crcfr_queue.sv =====
// ----------------------------------------------------------------------------
// crcfr_queue
// short register queue of classified bytes between front and back
// ----------------------------------------------------------------------------
module crcfr_queue #(
   parameter int DEPTH = crcfr_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  crcfr_pkg::entry_type push_entry,
   output logic                 full,
   input  logic                 pop,
   output crcfr_pkg::entry_type head_entry,
   output logic                 empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   crcfr_pkg::entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign empty      = (count_ff == '0);
   assign do_push    = push & ~full;
   assign do_pop     = pop & ~empty;
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count beyond depth");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (empty || full) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");
`endif

endmodule

// ===== hdl/crcfr_back.sv =====
// ----------------------------------------------------------------------------
// crcfr_back
// sequences header, payload and trailer bytes into the output register
// ----------------------------------------------------------------------------
module crcfr_back (
   input  logic                 clock,
   input  logic                 reset,
   // queue pop side
   input  logic                 q_empty,
   input  crcfr_pkg::entry_type q_head,
   output logic                 q_pop,
   // result stream
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // out_byte
   output logic                 rsp_tuser,   // end_of_frame
   output logic                 rsp_tlast    // run_last
);

   localparam logic [2:0] STEP_START  = 3'd0;
   localparam logic [2:0] STEP_LEN_LO = 3'd1;
   localparam logic [2:0] STEP_LEN_HI = 3'd2;
   localparam logic [2:0] STEP_DATA   = 3'd3;
   localparam logic [2:0] STEP_CRC_HI = 3'd4;
   localparam logic [2:0] STEP_CRC_LO = 3'd5;
   localparam logic [2:0] STEP_END    = 3'd6;

   crcfr_pkg::entry_type cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [2:0] step_ff, step_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_eof_ff, out_eof_in;
   logic       out_last_ff, out_last_in;
   logic       advance;
   logic       item_done;
   logic [7:0] step_byte;

   assign advance   = cur_valid_ff & (~out_valid_ff | rsp_tready);
   assign item_done = (step_ff == STEP_END) || (step_ff == STEP_DATA && !cur_ff.last);

   always_comb begin
      case (step_ff)
         STEP_START:  step_byte = cur_ff.start_code;
         STEP_LEN_LO: step_byte = cur_ff.payload_length[7:0];
         STEP_LEN_HI: step_byte = cur_ff.payload_length[15:8];
         STEP_DATA:   step_byte = cur_ff.data_byte;
         STEP_CRC_HI: step_byte = cur_ff.crc[15:8];
         STEP_CRC_LO: step_byte = cur_ff.crc[7:0];
         STEP_END:    step_byte = cur_ff.end_code;
         default:     step_byte = cur_ff.end_code;
      endcase
   end

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      step_in      = step_ff;
      q_pop        = 1'b0;
      if (advance && !item_done) begin
         step_in = step_ff + 3'd1;
      end else if (advance || !cur_valid_ff) begin
         // current item finished or none held: take the next one if any
         q_pop        = ~q_empty;
         cur_valid_in = ~q_empty;
         cur_in       = q_head;
         step_in      = q_head.first ? STEP_START : STEP_DATA;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_eof_in   = out_eof_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_byte_in  = step_byte;
         out_eof_in   = (step_ff == STEP_END);
         out_last_in  = item_done;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_byte_ff <= out_byte_in;
      out_eof_ff  <= out_eof_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         step_ff      <= STEP_START;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_eof_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef NO_ASSERTIONS
   a_eof_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_eof_ff) |-> out_last_ff)
      else $error("end of frame not on the last transfer of its item");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> step_ff <= STEP_END)
      else $error("step past end code");
   a_trailer_needs_last: assert property (@(posedge clock) disable iff (reset)
      (cur_valid_ff && step_ff > STEP_DATA) |-> cur_ff.last)
      else $error("trailer step on a byte that does not close the frame");
`endif

endmodule

// ===== sim/crc16_packet_framer_test.sv =====
// ----------------------------------------------------------------------------
// crc16_packet_framer_test
// self-checking bench for the stx/etx framer with crc-16/ccitt-false trailer
// ----------------------------------------------------------------------------
// Payload bytes go in on the req_ stream. A scoreboard keeps its own copy of
// the code registers, the running crc and the in-frame flag. From these it
// builds the framed bytes that each accepted byte must produce. Every rsp_
// transfer is compared with the oldest such byte. The run starts with directed
// frames: one-byte frames, length mismatches, ignored length fields, an unused
// register index and a code change in the middle of a frame. Random frames
// follow in four phases, each with its own code settings and idle pattern.
// ----------------------------------------------------------------------------

// one framed byte as seen on the rsp_ stream
typedef struct packed {
   logic [7:0] out_byte;
   logic       end_of_frame;
   logic       run_last;
} framed_byte_type;

class frame_scoreboard;
   framed_byte_type expected_bytes[$];
   logic [7:0]      start_code;
   logic [7:0]      end_code;
   logic [15:0]     running_crc;
   bit              in_frame;
   int              errors;

   function new();
      start_code  = crcfr_pkg::START_CODE_RESET;
      end_code    = crcfr_pkg::END_CODE_RESET;
      running_crc = crcfr_pkg::CRC_INIT;
      in_frame    = 1'b0;
      errors      = 0;
   endfunction

   // crc register update: fold the byte into the top, then shift eight times
   function logic [15:0] crc_update(logic [15:0] crc, logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      repeat (8) begin
         c = c[15] ? ((c << 1) ^ crcfr_pkg::CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   function void push_byte(logic [7:0] b, logic eof, logic run_last);
      framed_byte_type fb;
      fb.out_byte     = b;
      fb.end_of_frame = eof;
      fb.run_last     = run_last;
      expected_bytes.push_back(fb);
   endfunction

   function void set_code(logic [crcfr_pkg::CSR_INDEX_WIDTH-1:0] index,
                          logic [7:0] value);
      case (index)
         crcfr_pkg::CSR_START_CODE: start_code = value;
         crcfr_pkg::CSR_END_CODE:   end_code   = value;
         default: ;
      endcase
   endfunction

   function void note_payload(logic [7:0] data, logic [15:0] len, logic last);
      if (!in_frame) begin
         running_crc = crcfr_pkg::CRC_INIT;
         push_byte(start_code, 1'b0, 1'b0);
         push_byte(len[7:0], 1'b0, 1'b0);
         push_byte(len[15:8], 1'b0, 1'b0);
      end
      running_crc = crc_update(running_crc, data);
      if (last) begin
         push_byte(data, 1'b0, 1'b0);
         push_byte(running_crc[15:8], 1'b0, 1'b0);
         push_byte(running_crc[7:0], 1'b0, 1'b0);
         push_byte(end_code, 1'b1, 1'b1);
         in_frame    = 1'b0;
         running_crc = crcfr_pkg::CRC_INIT;
      end else begin
         push_byte(data, 1'b0, 1'b1);
         in_frame = 1'b1;
      end
   endfunction

   function void check_byte(logic [7:0] b, logic eof, logic run_last);
      framed_byte_type fb;
      if (expected_bytes.size() == 0) begin
         $error("unexpected transfer: out_byte %02h end_of_frame %0b run_last %0b",
                b, eof, run_last);
         errors++;
         return;
      end
      fb = expected_bytes.pop_front();
      if (b !== fb.out_byte) begin
         $error("out_byte: expected %02h, actual %02h", fb.out_byte, b);
         errors++;
      end
      if (eof !== fb.end_of_frame) begin
         $error("end_of_frame: expected %0b, actual %0b", fb.end_of_frame, eof);
         errors++;
      end
      if (run_last !== fb.run_last) begin
         $error("run_last: expected %0b, actual %0b", fb.run_last, run_last);
         errors++;
      end
   endfunction

   function int pending();
      return expected_bytes.size();
   endfunction
endclass

module crc16_packet_framer_test;

   // register index that decodes to nothing, the write must be dropped
   localparam logic [crcfr_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 'hA7;

   localparam int RANDOM_ITEMS = 340;     // split over the four phases
   localparam int LONG_HOLD    = 200;     // receiver hold-off, in cycles
   localparam int DRAIN_CYCLES = 20;      // quiet time after the last byte
   localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run

   logic                                  clock      = 1'b0;
   logic                                  reset      = 1'b1;
   logic                                  req_tvalid = 1'b0;
   logic                                  req_tready;
   logic [23:0]                           req_tdata  = '0;    // data_byte, payload_length
   logic                                  req_tlast  = 1'b0;  // last_byte
   logic                                  rsp_tvalid;
   logic                                  rsp_tready = 1'b0;
   logic [7:0]                            rsp_tdata;          // out_byte
   logic                                  rsp_tuser;          // end_of_frame
   logic                                  rsp_tlast;          // run_last
   logic                                  csr_valid  = 1'b0;
   logic                                  csr_ready;
   logic [crcfr_pkg::CSR_INDEX_WIDTH-1:0] csr_index  = '0;
   logic [7:0]                            csr_wdata  = '0;

   // idle pattern of the current phase, in percent per cycle
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   // long receiver hold-off, owned by its own forked process
   logic hold_off     = 1'b0;

   int items_sent  = 0;
   int cycle_count = 0;

   frame_scoreboard board = new();

   crc16_packet_framer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("crc16_packet_framer_test NOT OK");
         $finish;
      end
   end

   // receiver: check every accepted framed byte, then pick tready for the next
   // edge; the long hold-off overrides the random stall pattern
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_byte(rsp_tdata, rsp_tuser, rsp_tlast);
      end
      rsp_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
   end

   // offer one payload byte and hold it until the transfer; tvalid is only
   // dropped when a gap is wanted, so back-to-back bytes keep it high
   task automatic send_payload(input logic [7:0] data, input logic [15:0] len,
                               input logic last);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {len, data};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      board.note_payload(data, len, last);
      items_sent++;
   endtask

   // one frame of n bytes; the length field goes on the first byte only,
   // later bytes carry random lengths that the block must ignore
   task automatic send_frame(input int n, input logic [15:0] len_field);
      for (int i = 0; i < n; i++) begin
         send_payload(8'($urandom_range(255)),
                      (i == 0) ? len_field : 16'($urandom_range(65535)),
                      i == n - 1);
      end
   endtask

   // registers change only with nothing left in flight
   task automatic wait_drained();
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_code(input logic [crcfr_pkg::CSR_INDEX_WIDTH-1:0] index,
                             input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      board.set_code(index, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int          n;
      int          r;
      int          phase_items;
      int          start_items;
      bit          held;
      logic [15:0] len_field;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---------------- directed part, reset codes first ----------------
      // one-byte frames at both ends of the byte and length ranges
      send_payload(8'h00, 16'h0001, 1'b1);
      send_payload(8'hFF, 16'hFFFF, 1'b1);
      // length says one, frame has three; middle and last lengths ignored
      send_payload(8'h80, 16'h0001, 1'b0);
      send_payload(8'h01, 16'hFFFF, 1'b0);
      send_payload(8'h7F, 16'h1234, 1'b1);
      // length above the real count, split high and low bytes
      send_payload(8'h55, 16'h00FF, 1'b0);
      send_payload(8'hAA, 16'h8000, 1'b1);
      req_tvalid <= 1'b0;
      wait_drained();

      // unused index must leave both codes alone, then code extremes
      write_code(CSR_UNUSED, 8'hEE);
      send_payload(8'h3C, 16'h0100, 1'b1);
      req_tvalid <= 1'b0;
      wait_drained();
      write_code(crcfr_pkg::CSR_START_CODE, 8'h00);
      write_code(crcfr_pkg::CSR_END_CODE, 8'hFF);
      send_payload(8'h5A, 16'h0100, 1'b1);

      // code change in the middle of a frame: the new end code must close it
      send_payload(8'hC3, 16'h0002, 1'b0);
      req_tvalid <= 1'b0;
      wait_drained();
      write_code(crcfr_pkg::CSR_END_CODE, 8'h7E);
      write_code(crcfr_pkg::CSR_START_CODE, 8'hFF);
      send_payload(8'h3C, 16'hFFFE, 1'b1);
      send_payload(8'h96, 16'h0001, 1'b1);
      req_tvalid <= 1'b0;

      // ---------------- random frames in four phases ----------------
      for (int p = 0; p < 4; p++) begin
         wait_drained();
         case (p)
            0: begin
               write_code(crcfr_pkg::CSR_START_CODE, 8'hFF);
               write_code(crcfr_pkg::CSR_END_CODE, 8'h00);
               send_idle_pct  <= 0;
               recv_stall_pct <= 0;
            end
            1: begin
               write_code(crcfr_pkg::CSR_START_CODE, 8'($urandom_range(255)));
               write_code(crcfr_pkg::CSR_END_CODE, 8'($urandom_range(255)));
               send_idle_pct  <= 63;
               recv_stall_pct <= 0;
            end
            2: begin
               write_code(crcfr_pkg::CSR_START_CODE, 8'($urandom_range(255)));
               write_code(crcfr_pkg::CSR_END_CODE, 8'($urandom_range(255)));
               send_idle_pct  <= 0;
               recv_stall_pct <= 63;
            end
            default: begin
               write_code(crcfr_pkg::CSR_START_CODE, crcfr_pkg::START_CODE_RESET);
               write_code(crcfr_pkg::CSR_END_CODE, crcfr_pkg::END_CODE_RESET);
               send_idle_pct  <= 10;
               recv_stall_pct <= 10;
            end
         endcase

         start_items = items_sent;
         held        = 1'b0;
         phase_items = 0;
         while (phase_items < RANDOM_ITEMS / 4) begin
            // mostly short frames, now and then a long one
            r = $urandom_range(99);
            if (r < 60) begin
               n = $urandom_range(4, 1);
            end else if (r < 95) begin
               n = $urandom_range(16, 5);
            end else begin
               n = $urandom_range(48, 17);
            end
            // about a quarter of the frames carry a random length, which seldom matches
            len_field = ($urandom_range(3) == 0) ? 16'($urandom_range(65535, 1))
                                                 : 16'(n);

            // receiver stops for a long stretch while the sender keeps
            // offering, so the queue fills and req_tready drops
            if (p == 0 && !held && phase_items >= 20) begin
               held = 1'b1;
               fork
                  begin
                     hold_off <= 1'b1;
                     repeat (LONG_HOLD) @(posedge clock);
                     hold_off <= 1'b0;
                  end
               join_none
            end

            // sender waits for every framed byte before going on
            if (p == 2 && !held && phase_items >= 40) begin
               held = 1'b1;
               req_tvalid <= 1'b0;
               wait_drained();
            end

            send_frame(n, len_field);
            phase_items = items_sent - start_items;
         end
         req_tvalid <= 1'b0;
      end

      // ---------------- wind down ----------------
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.errors == 0 && board.pending() == 0) begin
         $display("crc16_packet_framer_test OK");
      end else begin
         $display("crc16_packet_framer_test NOT OK");
      end
      $finish;
   end

endmodule

// ===== crc16_packet_framer.f =====
hdl/crcfr_pkg.sv
hdl/crcfr_front.sv
hdl/crcfr_queue.sv
hdl/crcfr_back.sv
hdl/crc16_packet_framer.sv
sim/crc16_packet_framer_test.sv
